### src/block_quantized_int8_dot_defines.svh
// ----------------------------------------------------------------------------
// block_quantized_int8_dot_defines.svh
// Assertion macros shared by the block-quantized int8 dot product RTL.
// Each macro expects clk and rst_n to be in scope.
// ----------------------------------------------------------------------------
`ifndef BLOCK_QUANTIZED_INT8_DOT_DEFINES_SVH
`define BLOCK_QUANTIZED_INT8_DOT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BQD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BQD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bqd_pkg.sv
// ----------------------------------------------------------------------------
// bqd_pkg
// Widths, types and lane layout of the block-quantized int8 dot product.
// ----------------------------------------------------------------------------
package bqd_pkg;

  localparam int BLOCK_LEN   = 32;
  localparam int WORD_W      = 64;
  localparam int ELEM_W      = 8;
  localparam int LANE_ELEMS  = WORD_W / ELEM_W;
  localparam int LANE_CNT    = BLOCK_LEN / LANE_ELEMS;
  localparam int SCALE_W     = 16;

  localparam int PROD_W      = 2 * ELEM_W;
  localparam int LANE_SUM_W  = PROD_W + $clog2(LANE_ELEMS);
  localparam int DOT_W       = LANE_SUM_W + $clog2(LANE_CNT);
  localparam int SCL_PROD_W  = 2 * SCALE_W;
  localparam int TERM_W      = DOT_W + SCL_PROD_W;
  localparam int ACC_W       = 64;

  typedef logic signed [LANE_SUM_W-1:0] lane_sum_t;
  typedef logic signed [SCL_PROD_W-1:0] scl_prod_t;
  typedef logic signed [TERM_W-1:0]     term_t;
  typedef logic signed [ACC_W-1:0]      acc_t;

  // Per-stage control that travels alongside the payload.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctl_t;

endpackage

### src/block_quantized_int8_dot.sv
// A result for the last block passes the lane, merge, scaled-term and result registers before it appears.
// Throughput: one block pair per cycle unless stalled; four lanes of eight byte multipliers
//   feed a lane merge, a scale multiplier and a saturating 64-bit adder.
// The whole pipeline holds while a finished result waits under out_stall.
// Reset (rst_n low, synchronous) clears the running sum, clip flag and valids.
// ----------------------------------------------------------------------------
// block_quantized_int8_dot
// Block-quantized int8 dot product: each transfer carries 32 weight bytes,
// 32 activation bytes and a Q1.15 scale per side. The scaled block dot
// product (30 fractional bits) accumulates with saturation; the block marked
// last emits the sum with its clip flag and clears the accumulator.
// ----------------------------------------------------------------------------
module block_quantized_int8_dot
  import bqd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [WORD_W-1:0]         in_weight_word_0,
  input  logic [WORD_W-1:0]         in_weight_word_1,
  input  logic [WORD_W-1:0]         in_weight_word_2,
  input  logic [WORD_W-1:0]         in_weight_word_3,
  input  logic [WORD_W-1:0]         in_act_word_0,
  input  logic [WORD_W-1:0]         in_act_word_1,
  input  logic [WORD_W-1:0]         in_act_word_2,
  input  logic [WORD_W-1:0]         in_act_word_3,
  input  logic signed [SCALE_W-1:0] in_weight_scale,
  input  logic signed [SCALE_W-1:0] in_act_scale,
  input  logic                      in_last_block,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [ACC_W-1:0]   out_dot_value,
  output logic                      out_saturated
);

  // Pipeline advance: everything moves unless a result is held at the output.
  logic        adv;

  logic [WORD_W-1:0] w_word [LANE_CNT];
  logic [WORD_W-1:0] a_word [LANE_CNT];
  lane_sum_t         lane_sum [LANE_CNT];

  scl_prod_t   scl_prod_r;
  term_t       term;

  // Control follows the data: stage 1 = lanes, 2 = merge, 3 = scaled term.
  stage_ctl_t  s1_ctl_r;
  stage_ctl_t  s2_ctl_r;
  stage_ctl_t  s3_ctl_r;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  assign w_word[0] = in_weight_word_0;
  assign w_word[1] = in_weight_word_1;
  assign w_word[2] = in_weight_word_2;
  assign w_word[3] = in_weight_word_3;
  assign a_word[0] = in_act_word_0;
  assign a_word[1] = in_act_word_1;
  assign a_word[2] = in_act_word_2;
  assign a_word[3] = in_act_word_3;

  // One lane per 64-bit word pair.
  for (genvar g = 0; g < LANE_CNT; g++) begin : g_lane
    bqd_lane u_lane (
      .clk      (clk),
      .adv      (adv),
      .w_word   (w_word[g]),
      .a_word   (a_word[g]),
      .lane_sum (lane_sum[g])
    );
  end

  // Scale product in step with the lanes: Q1.15 x Q1.15 gives Q2.30, exact.
  always_ff @(posedge clk) begin
    if (adv) begin
      scl_prod_r <= in_weight_scale * in_act_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= '{valid: in_valid, last: in_last_block};
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  bqd_merge u_merge (
    .clk      (clk),
    .adv      (adv),
    .lane_sum (lane_sum),
    .scl_prod (scl_prod_r),
    .term     (term)
  );

  // Accumulate the scaled term; transfer the sum out on the last block.
  bqd_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .s3_ctl        (s3_ctl_r),
    .term          (term),
    .out_valid     (out_valid),
    .out_dot_value (out_dot_value),
    .out_saturated (out_saturated)
  );

endmodule

### src/bqd_lane.sv
// ----------------------------------------------------------------------------
// bqd_lane
// One multiplier lane: eight signed byte products of one word pair, summed.
// ----------------------------------------------------------------------------
module bqd_lane
  import bqd_pkg::*;
(
  input  logic                clk,
  input  logic                adv,
  input  logic [WORD_W-1:0]   w_word,
  input  logic [WORD_W-1:0]   a_word,
  output lane_sum_t           lane_sum
);

  logic signed [PROD_W-1:0] prod [LANE_ELEMS];
  lane_sum_t                sum_nxt;
  lane_sum_t                sum_r;

  always_comb begin
    for (int i = 0; i < LANE_ELEMS; i++) begin
      prod[i] = $signed(w_word[ELEM_W*i +: ELEM_W]) * $signed(a_word[ELEM_W*i +: ELEM_W]);
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LANE_ELEMS; i++) begin
      sum_nxt = sum_nxt + LANE_SUM_W'(prod[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
    end
  end

  assign lane_sum = sum_r;

endmodule

### src/bqd_merge.sv
// ----------------------------------------------------------------------------
// bqd_merge
// Combine the lane sums into the block dot product, then scale it.
// ----------------------------------------------------------------------------
module bqd_merge
  import bqd_pkg::*;
(
  input  logic       clk,
  input  logic       adv,
  input  lane_sum_t  lane_sum [LANE_CNT],
  input  scl_prod_t  scl_prod,
  output term_t      term
);

  logic signed [DOT_W-1:0] dot_nxt;
  logic signed [DOT_W-1:0] dot_r;
  scl_prod_t               scl_r;
  term_t                   term_r;

  always_comb begin
    dot_nxt = '0;
    for (int i = 0; i < LANE_CNT; i++) begin
      dot_nxt = dot_nxt + DOT_W'(lane_sum[i]);
    end
  end

  // Register the lane sum, then multiply it by the registered scale product into the term register.
  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r  <= dot_nxt;
      scl_r  <= scl_prod;
      term_r <= dot_r * scl_r;
    end
  end

  assign term = term_r;

endmodule

### src/bqd_accum.sv
// ----------------------------------------------------------------------------
// bqd_accum
// Saturating 64-bit accumulator with clip flag and the result register.
// ----------------------------------------------------------------------------
`include "block_quantized_int8_dot_defines.svh"

module bqd_accum
  import bqd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        adv,
  input  stage_ctl_t  s3_ctl,
  input  term_t       term,
  output logic        out_valid,
  output acc_t        out_dot_value,
  output logic        out_saturated
);

  localparam acc_t ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  acc_t             sum_r;
  logic             clip_r;
  logic             out_valid_r;
  acc_t             out_dot_value_r;
  logic             out_saturated_r;

  logic [ACC_W:0]   sum_ext;
  logic             ovf;
  acc_t             sum_nxt;
  logic             clip_nxt;
  logic             emit;

  assign sum_ext  = {sum_r[ACC_W-1], sum_r} + (ACC_W+1)'(term);
  assign ovf      = sum_ext[ACC_W] ^ sum_ext[ACC_W-1];
  assign sum_nxt  = ovf ? (sum_ext[ACC_W] ? ACC_MIN : ACC_MAX) : acc_t'(sum_ext[ACC_W-1:0]);
  assign clip_nxt = clip_r | ovf;
  assign emit     = s3_ctl.valid & s3_ctl.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
      if (emit) begin
        sum_r  <= '0;
        clip_r <= 1'b0;
      end else if (s3_ctl.valid) begin
        sum_r  <= sum_nxt;
        clip_r <= clip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_dot_value_r <= sum_nxt;
      out_saturated_r <= clip_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_dot_value = out_dot_value_r;
  assign out_saturated = out_saturated_r;

  `BQD_ASSERT_NEXT(a_clear_after_last, adv && emit, (sum_r == '0) && !clip_r, "sum not cleared after last block")
  `BQD_ASSERT_NEXT(a_hold_when_blocked, !adv, $stable(sum_r) && $stable(clip_r), "accumulator moved while blocked")
  `BQD_ASSERT_NEXT(a_result_only_on_last, adv && !emit, !out_valid_r, "result raised without a last block")

endmodule
